// ===== hdl/feal_pkg.sv =====
// ----------------------------------------------------------------------------
// feal_pkg
// shared widths and the byte substitution step of the feal round function
// ----------------------------------------------------------------------------
package feal_pkg;

	localparam int BLK_W  = 64;
	localparam int HALF_W = 32;
	localparam int SK_W   = 16;
	localparam int KEY_W  = 64;

	// s(a, b, d) = rotl2((a + b + d) mod 256)
	function automatic logic [7:0] s_fn(input logic [7:0] a, input logic [7:0] b,
			input logic d);
		logic [7:0] x;
		x = a + b + {7'd0, d};
		return {x[5:0], x[7:6]};
	endfunction

endpackage

// ===== hdl/feal_fn.sv =====
// ----------------------------------------------------------------------------
// feal_fn
// shared f / fk unit, used for the key schedule and for every cipher round
// ----------------------------------------------------------------------------
module feal_fn (
	input  logic [feal_pkg::HALF_W-1:0] a,
	input  logic [feal_pkg::SK_W-1:0]   kk,
	input  logic [feal_pkg::HALF_W-1:0] x,
	output logic [feal_pkg::HALF_W-1:0] y
);

	logic [7:0] a0, a1, a2, a3;
	logic [7:0] x0, x1, x2, x3;
	logic [7:0] f0, f1, f2, f3;
	logic [7:0] g1, g2;

	assign {a0, a1, a2, a3} = a;
	assign {x0, x1, x2, x3} = x;

	assign g1 = a0 ^ a1 ^ kk[15:8];
	assign g2 = a2 ^ a3 ^ kk[7:0];
	assign f1 = feal_pkg::s_fn(g1, g2 ^ x0, 1'b1);
	assign f2 = feal_pkg::s_fn(g2, f1 ^ x1, 1'b0);
	assign f0 = feal_pkg::s_fn(a0, f1 ^ x2, 1'b0);
	assign f3 = feal_pkg::s_fn(a3, f2 ^ x3, 1'b1);

	assign y = {f0, f1, f2, f3};

endmodule

// ===== hdl/feal_skey_ram.sv =====
// ----------------------------------------------------------------------------
// feal_skey_ram
// round subkey memory, two subkeys per row, one write and one registered read
// ----------------------------------------------------------------------------
module feal_skey_ram #(
	parameter int AW = 4
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [feal_pkg::HALF_W-1:0] wdata,
	input  logic [AW-1:0]               raddr,
	output logic [feal_pkg::HALF_W-1:0] rdata
);

	logic [feal_pkg::HALF_W-1:0] mem [2**AW];
	logic [feal_pkg::HALF_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/feal_block_cipher.sv =====
// ----------------------------------------------------------------------------
// feal_block_cipher
// feal-n block cipher, ecb, one shared f unit run under a small sequencer
// ----------------------------------------------------------------------------
//  channel  signals                         direction
//  in       in_valid in_stall block_in      word in: block and direction
//           decrypt
//  out      out_valid out_stall block_out   word out: result block
//  cfg      cfg_wr cipher_key               key write, no read-back
//
//  a block runs from acceptance to the next acceptance through the idle state,
//  the whitening state, one round per cycle on the f unit and the output
//  state; the subkey memory read is issued in the cycle before its round.
//  the first block after reset or a key write adds a key schedule pass on
//  the same f unit. reset leaves the schedule not expanded.
//  a stalled output holds the output state until the output register frees.
// ----------------------------------------------------------------------------
module feal_block_cipher #(
	parameter int ROUNDS = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr,
	input  logic [feal_pkg::KEY_W-1:0] cipher_key,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [feal_pkg::BLK_W-1:0] block_in,
	input  logic                       decrypt,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [feal_pkg::BLK_W-1:0] block_out
);

	localparam int SCHED_ITERS = (ROUNDS + 9) / 2;
	localparam int RROWS       = (ROUNDS + 1) / 2;
	localparam int KW          = $clog2(ROUNDS);
	localparam int RW          = KW - 1;
	localparam int CW          = $clog2(ROUNDS + 9);
	localparam int HW          = feal_pkg::HALF_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_KEYX,
		ST_PRE,
		ST_RND,
		ST_POST
	} state_t;

	state_t                      state_q;
	logic                        ready_q;
	logic                        out_valid_q;
	logic [feal_pkg::KEY_W-1:0]  key_q;
	logic [CW-1:0]               cnt_q;

	logic [feal_pkg::BLK_W-1:0]  blk_q;
	logic                        dec_q;
	logic [HW-1:0]               a_q, b_q, d_q;
	logic [KW-1:0]               k_q;
	logic [feal_pkg::SK_W-1:0]   wk_q [8];
	logic [feal_pkg::BLK_W-1:0]  block_out_q;

	logic [HW-1:0]               fn_a, fn_x, fn_y;
	logic [feal_pkg::SK_W-1:0]   fn_k, sk_cur;
	logic [KW-1:0]               k_next, k_first;
	logic [RW-1:0]               raddr;
	logic [HW-1:0]               rdata;
	logic                        ram_we;
	logic [feal_pkg::BLK_W-1:0]  wk_a, wk_b, pre_key, post_key, pre_t, post_res;
	logic                        out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign block_out = block_out_q;
	assign out_free  = !out_valid_q || !out_stall;

	// subkey selection and read address
	assign sk_cur  = k_q[0] ? rdata[15:0] : rdata[31:16];
	assign k_next  = dec_q ? k_q - KW'(1) : k_q + KW'(1);
	assign k_first = dec_q ? KW'(ROUNDS - 1) : '0;
	assign raddr   = (state_q == ST_PRE) ? k_first[KW-1:1] : k_next[KW-1:1];
	assign ram_we  = (state_q == ST_KEYX) && (cnt_q < CW'(RROWS));

	always_comb begin
		fn_a = blk_q[HW-1:0];
		fn_k = sk_cur;
		fn_x = '0;
		if (state_q == ST_KEYX) begin
			fn_a = a_q;
			fn_k = '0;
			fn_x = b_q ^ d_q;
		end
	end

	// whitening
	assign wk_a     = {wk_q[0], wk_q[1], wk_q[2], wk_q[3]};
	assign wk_b     = {wk_q[4], wk_q[5], wk_q[6], wk_q[7]};
	assign pre_key  = dec_q ? wk_b : wk_a;
	assign post_key = dec_q ? wk_a : wk_b;
	assign pre_t    = blk_q ^ pre_key;
	assign post_res = {blk_q[HW-1:0], blk_q[2*HW-1:HW] ^ blk_q[HW-1:0]} ^ post_key;

	feal_fn u_fn (
		.a  (fn_a),
		.kk (fn_k),
		.x  (fn_x),
		.y  (fn_y)
	);

	feal_skey_ram #(
		.AW (RW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_q[RW-1:0]),
		.wdata (fn_y),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ready_q     <= 1'b0;
			out_valid_q <= 1'b0;
			key_q       <= '0;
			cnt_q       <= '0;
		end else begin
			if (cfg_wr) begin
				key_q <= cipher_key;
			end
			if (cfg_wr) begin
				ready_q <= 1'b0;
			end else if (state_q == ST_KEYX && cnt_q == CW'(SCHED_ITERS - 1)) begin
				ready_q <= 1'b1;
			end
			if (state_q == ST_POST && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (in_valid) begin
						state_q <= ready_q ? ST_PRE : ST_KEYX;
					end
				end
				ST_KEYX: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(SCHED_ITERS - 1)) begin
						state_q <= ST_PRE;
					end
				end
				ST_PRE: begin
					cnt_q   <= '0;
					state_q <= ST_RND;
				end
				ST_RND: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(ROUNDS - 1)) begin
						state_q <= ST_POST;
					end
				end
				ST_POST: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					blk_q <= block_in;
					dec_q <= decrypt;
					a_q   <= key_q[2*HW-1:HW];
					b_q   <= key_q[HW-1:0];
					d_q   <= '0;
				end
			end
			ST_KEYX: begin
				d_q <= a_q;
				a_q <= b_q;
				b_q <= fn_y;
				// whitening subkeys live in flops
				for (int s = 0; s < 8; s++) begin
					if ({cnt_q, 1'b0} == (CW + 1)'(ROUNDS + s)) begin
						wk_q[s] <= fn_y[31:16];
					end
					if ({cnt_q, 1'b1} == (CW + 1)'(ROUNDS + s)) begin
						wk_q[s] <= fn_y[15:0];
					end
				end
			end
			ST_PRE: begin
				blk_q <= {pre_t[2*HW-1:HW], pre_t[HW-1:0] ^ pre_t[2*HW-1:HW]};
				k_q   <= k_first;
			end
			ST_RND: begin
				blk_q <= {blk_q[HW-1:0], fn_y ^ blk_q[2*HW-1:HW]};
				k_q   <= k_next;
			end
			ST_POST: begin
				if (out_free) begin
					block_out_q <= post_res;
				end
			end
			default: begin
				blk_q <= blk_q;
			end
		endcase
	end

endmodule

// ===== hdl/feal_checker.sv =====
// ----------------------------------------------------------------------------
// feal_checker
// port-level checks on the cipher's handshakes, bound to the top level
// ----------------------------------------------------------------------------
module feal_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [feal_pkg::BLK_W-1:0] block_out
);

	// stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(block_out))
		else $error("stalled output word changed");

	// busy right after an input word is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again while busy");

	// a new result only appears at the end of busy work
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without work");

	// no result in the cycle right after an accept
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !$rose(out_valid))
		else $error("result too early");

endmodule

bind feal_block_cipher feal_checker u_feal_checker (.*);
